// ===== rtl/core/crt_pkg.sv =====
// Shared types, codes and helper functions for the command retransmit tracker.
`timescale 1ns / 1ps

package crt_pkg;

    // Event codes carried by one input beat
    typedef enum logic [1:0] {
        K_REGISTER = 2'd0,
        K_SENT     = 2'd1,
        K_TICK     = 2'd2,
        K_ACK      = 2'd3
    } t_kind;

    // Configuration register indexes
    localparam logic [1:0] CFG_INITIAL_RTT = 2'd0;
    localparam logic [1:0] CFG_MIN_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MAX_TIMEOUT = 2'd2;

    localparam int          TABLE_DEPTH_DEF   = 16;
    localparam logic [31:0] INITIAL_RTT_RESET = 32'd200;
    localparam logic [31:0] MIN_TIMEOUT_RESET = 32'd50;
    localparam logic [31:0] MAX_TIMEOUT_RESET = 32'd5000;

    // Table word: sequence, sent flag, last send time
    localparam int ENTRY_W = 65;

    // Write source for the entry table
    typedef enum logic [2:0] {
        W_NONE,
        W_NEW,
        W_STAMP,
        W_TICK,
        W_SHIFT
    } t_wsel;

    // Result beat kinds
    typedef enum logic [2:0] {
        E_FAIL,
        E_OKZERO,
        E_NEW,
        E_PEND_MID,
        E_PEND_LAST
    } t_esel;

    // Controller to datapath commands
    typedef struct packed {
        logic  load;
        logic  rd;
        logic  rd_next;
        logic  idx_clr;
        logic  idx_inc;
        logic  cand_bump;
        t_wsel wr_sel;
        logic  hit;
        logic  obs1;
        logic  obs2;
        logic  cnt_inc;
        logic  cnt_dec;
        logic  commit_seq;
        logic  pend_load;
        logic  emit;
        t_esel emit_sel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  at_end;
        logic  match;
        logic  due;
        logic  sample_ok;
        logic  last_pos;
        logic  pend_vld;
    } t_status;

    // Sequence increment that never lands on zero
    function automatic logic [31:0] bump_seq(input logic [31:0] s);
        logic [31:0] t;
        t = s + 32'd1;
        return (t == 32'd0) ? 32'd1 : t;
    endfunction

    function automatic logic [31:0] load_srtt(input logic [31:0] v);
        return (v > 32'd1) ? v : 32'd1;
    endfunction

    function automatic logic [31:0] load_var(input logic [31:0] srtt);
        return (srtt[31:1] > 31'd1) ? {1'b0, srtt[31:1]} : 32'd1;
    endfunction

endpackage

// ===== rtl/core/crt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/crt_ctrl.sv =====
// Sequencing state machine for the retransmit tracker.
`timescale 1ns / 1ps

module crt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  crt_pkg::t_status i_status,
    output crt_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    import crt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CK,
        S_OBS1,
        S_OBS2,
        S_SH_CHK,
        S_SH_WR,
        S_ACK_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    t_cmd   cmd;

    // Next state and per-cycle commands
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                if (i_status.kind == K_REGISTER && i_status.full) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = E_FAIL;
                    n_state      = S_IDLE;
                end else if (i_status.at_end) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                    case (i_status.kind)
                        K_REGISTER: begin
                            cmd.wr_sel     = W_NEW;
                            cmd.cnt_inc    = 1'b1;
                            cmd.commit_seq = 1'b1;
                            cmd.emit_sel   = E_NEW;
                        end
                        K_TICK: begin
                            cmd.emit_sel = i_status.pend_vld ? E_PEND_LAST : E_FAIL;
                        end
                        default: begin
                            cmd.emit_sel = E_FAIL;
                        end
                    endcase
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_CK;
                end
            end
            S_CK: begin
                n_state = S_RD;
                case (i_status.kind)
                    K_REGISTER: begin
                        if (i_status.match) begin
                            cmd.cand_bump = 1'b1;
                            cmd.idx_clr   = 1'b1;
                        end else begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                    K_SENT: begin
                        if (i_status.match) begin
                            cmd.wr_sel   = W_STAMP;
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = E_OKZERO;
                            n_state      = S_IDLE;
                        end else begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                    K_TICK: begin
                        cmd.idx_inc = 1'b1;
                        if (i_status.due) begin
                            cmd.wr_sel    = W_TICK;
                            cmd.pend_load = 1'b1;
                            cmd.emit      = i_status.pend_vld;
                            cmd.emit_sel  = E_PEND_MID;
                        end
                    end
                    default: begin
                        if (i_status.match) begin
                            cmd.hit = 1'b1;
                            n_state = i_status.sample_ok ? S_OBS1 : S_SH_CHK;
                        end else begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                endcase
            end
            S_OBS1: begin
                cmd.obs1 = 1'b1;
                n_state  = S_OBS2;
            end
            S_OBS2: begin
                cmd.obs2 = 1'b1;
                n_state  = S_SH_CHK;
            end
            S_SH_CHK: begin
                if (i_status.last_pos) begin
                    cmd.cnt_dec = 1'b1;
                    n_state     = S_ACK_DONE;
                end else begin
                    cmd.rd      = 1'b1;
                    cmd.rd_next = 1'b1;
                    n_state     = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.wr_sel  = W_SHIFT;
                cmd.idx_inc = 1'b1;
                n_state     = S_SH_CHK;
            end
            S_ACK_DONE: begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = E_OKZERO;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule

// ===== rtl/core/crt_dpath.sv =====
// Entry table, RTT estimator, timeout and result registers of the tracker.
`timescale 1ns / 1ps

module crt_dpath #(
    parameter int DEPTH = crt_pkg::TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  crt_pkg::t_cmd    i_cmd,
    output crt_pkg::t_status o_status,
    input  logic [1:0]       i_kind,
    input  logic [31:0]      i_sequence_req,
    input  logic [31:0]      i_now_ms,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output logic             o_result_valid,
    output logic [31:0]      o_sequence_out,
    output logic             o_ok,
    output logic             o_last,
    output logic [31:0]      o_retry_timeout_ms
);

    import crt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = $clog2(DEPTH + 1);

    t_kind       r_kind;
    logic [31:0] r_seq_req, r_now;
    logic [IW-1:0] r_cnt, r_idx;
    logic [31:0] r_cand, r_next_seq;
    logic [31:0] r_srtt, r_var, r_rto, r_min, r_max;
    logic [31:0] r_sample, r_delta, r_wv, r_wr;
    logic        r_pend_vld;
    logic [31:0] r_pend_seq;
    logic        r_valid, r_ok, r_last;
    logic [31:0] r_seq_out, r_rto_out;

    logic [ENTRY_W-1:0] rdata, wdata;
    logic [31:0]        rd_seq, rd_time;
    logic               rd_sent;
    logic               we;
    logic [IW:0]        idx_p1;
    logic [AW-1:0]      raddr;

    assign rd_seq  = rdata[64:33];
    assign rd_sent = rdata[32];
    assign rd_time = rdata[31:0];
    assign idx_p1  = {1'b0, r_idx} + {{IW{1'b0}}, 1'b1};
    assign raddr   = i_cmd.rd_next ? idx_p1[AW-1:0] : r_idx[AW-1:0];

    // Table write source
    always_comb begin
        we    = 1'b1;
        wdata = rdata;
        case (i_cmd.wr_sel)
            W_NEW:   wdata = {r_cand, 1'b0, 32'd0};
            W_STAMP: wdata = {rd_seq, 1'b1, r_now};
            W_TICK:  wdata = {rd_seq, rd_sent, r_now};
            W_SHIFT: wdata = rdata;
            default: we = 1'b0;
        endcase
    end

    crt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Retry timeout: srtt + 4*var, saturated, then clamped
    logic [31:0] win, t_sat, t_lo, rto_next;
    logic [32:0] t_sum;
    always_comb begin
        win      = (|r_var[31:30]) ? 32'hFFFF_FFFF : {r_var[29:0], 2'b00};
        t_sum    = {1'b0, r_srtt} + {1'b0, win};
        t_sat    = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
        t_lo     = (t_sat < r_min) ? r_min : t_sat;
        rto_next = (t_lo > r_max) ? r_max : t_lo;
    end

    // Entry checks against the word just read
    logic [31:0] age, match_val;
    logic        time_ok;
    assign age       = r_now - rd_time;
    assign time_ok   = (r_now >= rd_time);
    assign match_val = (r_kind == K_REGISTER) ? r_cand : r_seq_req;

    // Estimator terms: first step products, second step sums
    logic [31:0] delta_n, wv_n, wr_n;
    logic [33:0] v3;
    logic [34:0] s7;
    logic [32:0] sv, sr;
    always_comb begin
        delta_n = (r_sample > r_srtt) ? (r_sample - r_srtt) : (r_srtt - r_sample);
        v3      = {2'b00, r_var} + {1'b0, r_var, 1'b0};
        wv_n    = (|v3[33:32]) ? 32'hFFFF_FFFF : v3[31:0];
        s7      = {r_srtt, 3'b000} - {3'b000, r_srtt};
        wr_n    = (|s7[34:32]) ? 32'hFFFF_FFFF : s7[31:0];
        sv      = {1'b0, r_wv} + {1'b0, r_delta};
        sr      = {1'b0, r_wr} + {1'b0, r_sample};
    end

    // Result beat contents
    logic [31:0] e_seq;
    logic        e_ok, e_last;
    always_comb begin
        e_seq  = 32'd0;
        e_ok   = 1'b1;
        e_last = 1'b1;
        case (i_cmd.emit_sel)
            E_FAIL:      e_ok = 1'b0;
            E_NEW:       e_seq = r_cand;
            E_PEND_MID: begin
                e_seq  = r_pend_seq;
                e_last = 1'b0;
            end
            E_PEND_LAST: e_seq = r_pend_seq;
            default:     e_seq = 32'd0;
        endcase
    end

    // Control state: counts, sequence, estimator, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_idx      <= '0;
            r_next_seq <= 32'd1;
            r_srtt     <= load_srtt(INITIAL_RTT_RESET);
            r_var      <= load_var(load_srtt(INITIAL_RTT_RESET));
            r_min      <= MIN_TIMEOUT_RESET;
            r_max      <= MAX_TIMEOUT_RESET;
            r_rto      <= 32'd0;
            r_pend_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_rto   <= rto_next;
            r_valid <= i_cmd.emit;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INITIAL_RTT: begin
                        r_srtt <= load_srtt(i_cfg_data);
                        r_var  <= load_var(load_srtt(i_cfg_data));
                    end
                    CFG_MIN_TIMEOUT: r_min <= i_cfg_data;
                    CFG_MAX_TIMEOUT: r_max <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.obs2) begin
                r_var  <= sv[32] ? 32'hFFFF_FFFF : {2'b00, sv[31:2]};
                r_srtt <= sr[32] ? 32'hFFFF_FFFF : {3'b000, sr[31:3]};
            end
            if (i_cmd.load || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_p1[IW-1:0];
            end
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + {{(IW-1){1'b0}}, 1'b1};
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - {{(IW-1){1'b0}}, 1'b1};
            end
            if (i_cmd.commit_seq) begin
                r_next_seq <= bump_seq(r_cand);
            end
            if (i_cmd.load) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.pend_load) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= t_kind'(i_kind);
            r_seq_req <= i_sequence_req;
            r_now     <= i_now_ms;
            r_cand    <= r_next_seq;
        end else if (i_cmd.cand_bump) begin
            r_cand <= bump_seq(r_cand);
        end
        if (i_cmd.hit) begin
            r_sample <= age;
        end
        if (i_cmd.obs1) begin
            r_delta <= delta_n;
            r_wv    <= wv_n;
            r_wr    <= wr_n;
        end
        if (i_cmd.pend_load) begin
            r_pend_seq <= rd_seq;
        end
        if (i_cmd.emit) begin
            r_seq_out <= e_seq;
            r_ok      <= e_ok;
            r_last    <= e_last;
            r_rto_out <= r_rto;
        end
    end

    assign o_status.kind      = r_kind;
    assign o_status.full      = (r_cnt == IW'(DEPTH));
    assign o_status.at_end    = (r_idx == r_cnt);
    assign o_status.match     = (rd_seq == match_val);
    assign o_status.due       = rd_sent && time_ok && (age >= r_rto);
    assign o_status.sample_ok = rd_sent && time_ok;
    assign o_status.last_pos  = (idx_p1 == {1'b0, r_cnt});
    assign o_status.pend_vld  = r_pend_vld;

    assign o_result_valid     = r_valid;
    assign o_sequence_out     = r_seq_out;
    assign o_ok               = r_ok;
    assign o_last             = r_last;
    assign o_retry_timeout_ms = r_rto_out;

endmodule

// ===== rtl/core/command_retransmit_tracker.sv =====
// Top level of the command retransmit tracker: controller plus datapath.
// Each item scans the table from its first entry: register and tick scan all N pending entries,
// and a register restarts the scan for each pending sequence that its candidate hits; mark sent
// stops at the hit, and an ack hit updates the RTT estimate when sampled, then moves later entries up.
// One item at a time; the next is accepted at the edge that ends the final beat.
// Receiver cannot stall. Synchronous active low reset empties the table, loads defaults.
`timescale 1ns / 1ps

module command_retransmit_tracker #(
    parameter int TABLE_DEPTH = crt_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_sequence_req,
    input  logic [31:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_result_valid,
    output logic [31:0] o_sequence_out,
    output logic        o_ok,
    output logic        o_last,
    output logic [31:0] o_retry_timeout_ms
);

    import crt_pkg::*;

    t_cmd    cmd;
    t_status status;

    crt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    crt_dpath #(
        .DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_kind             (i_kind),
        .i_sequence_req     (i_sequence_req),
        .i_now_ms           (i_now_ms),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_result_valid     (o_result_valid),
        .o_sequence_out     (o_sequence_out),
        .o_ok               (o_ok),
        .o_last             (o_last),
        .o_retry_timeout_ms (o_retry_timeout_ms)
    );

    // A result beat only follows a cycle of work on an item
    a_beat_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(o_busy))
        else $error("result beat without active item");

    // A failed beat carries no sequence
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_ok) |-> (o_sequence_out == 32'd0))
        else $error("failed beat with nonzero sequence");

    // Only resubmissions may leave the item open
    a_mid_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |-> (o_ok && o_sequence_out != 32'd0))
        else $error("non-final beat is not a resubmission");

endmodule

// ===== verif/command_retransmit_tracker_tb.sv =====
// Self-checking testbench for the command retransmit tracker: directed table plus random traffic.
`timescale 1ns / 1ps

module command_retransmit_tracker_tb;
    import crt_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int IDLE_PCT  = 29;
    localparam int STALL_MAX = 5000;
    localparam int ITEMS_PER_PHASE = 14;

    typedef struct {
        logic [31:0] seq;
        logic        ok;
        logic        last;
        logic [31:0] rto;
    } t_beat;

    typedef struct {
        t_kind       kind;
        logic [31:0] seq;
        logic [31:0] now;
        bit          typed;
        logic [31:0] exp_seq;
        logic        exp_ok;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_kind = K_REGISTER;
    logic [31:0] i_sequence_req = '0;
    logic [31:0] i_now_ms = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_INITIAL_RTT;
    logic [31:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_result_valid;
    logic [31:0] o_sequence_out;
    logic        o_ok;
    logic        o_last;
    logic [31:0] o_retry_timeout_ms;

    command_retransmit_tracker dut (.*);

    // Shadow copy of the tracker state
    logic [31:0] sh_init = INITIAL_RTT_RESET;
    logic [31:0] sh_min = MIN_TIMEOUT_RESET;
    logic [31:0] sh_max = MAX_TIMEOUT_RESET;
    bit          sh_valid[DEPTH];
    logic [31:0] sh_seq[DEPTH];
    bit          sh_sent[DEPTH];
    logic [31:0] sh_stamp[DEPTH];
    logic [31:0] sh_next = 32'd1;
    logic [31:0] sh_srtt = 32'd200;
    logic [31:0] sh_var = 32'd100;

    t_beat       pending_beats[$];
    int          errors = 0;
    int          mismatches = 0;
    int          stall_cnt = 0;
    bit          no_idle = 1'b0;
    logic [31:0] wall_ms = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] clamped_timeout();
        logic [31:0] t;
        t = sat32(64'(sh_srtt) + 64'(sat32(64'(sh_var) * 4)));
        if (t < sh_min) t = sh_min;
        if (t > sh_max) t = sh_max;
        return t;
    endfunction

    function automatic int lookup(input logic [31:0] s);
        for (int i = 0; i < DEPTH; i++)
            if (sh_valid[i] && sh_seq[i] == s) return i;
        return -1;
    endfunction

    function automatic logic [31:0] next_nonzero(input logic [31:0] s);
        return (s + 32'd1 == 32'd0) ? 32'd1 : s + 32'd1;
    endfunction

    function automatic void reload_rtt();
        sh_srtt = (sh_init > 32'd1) ? sh_init : 32'd1;
        sh_var = ((sh_srtt >> 1) > 32'd1) ? (sh_srtt >> 1) : 32'd1;
    endfunction

    // RTT estimator update from one sample
    function automatic void fold_sample(input logic [31:0] sample);
        logic [31:0] delta;
        logic [63:0] wv, wr;
        delta = (sample > sh_srtt) ? sample - sh_srtt : sh_srtt - sample;
        wv = 64'(sat32(64'(sh_var) * 3)) + 64'(delta);
        wr = 64'(sat32(64'(sh_srtt) * 7)) + 64'(sample);
        sh_var = (wv > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(wv / 4);
        sh_srtt = (wr > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(wr / 8);
    endfunction

    // Work out the result beats of one accepted command
    function automatic void predict_beats(input t_kind k, input logic [31:0] s,
                                          input logic [31:0] now);
        t_beat b[$];
        int    cnt, idx;
        logic [31:0] rto;
        cnt = 0;
        case (k)
            K_REGISTER: begin
                while (cnt < DEPTH && sh_valid[cnt]) cnt++;
                if (cnt >= DEPTH) begin
                    b = {b, t_beat'{32'd0, 1'b0, 1'b1, 32'd0}};
                end else begin
                    for (int i = 0; i <= DEPTH && lookup(sh_next) >= 0; i++)
                        sh_next = next_nonzero(sh_next);
                    sh_valid[cnt] = 1'b1;
                    sh_seq[cnt] = sh_next;
                    sh_sent[cnt] = 1'b0;
                    sh_stamp[cnt] = '0;
                    b = {b, t_beat'{sh_next, 1'b1, 1'b1, 32'd0}};
                    sh_next = next_nonzero(sh_next);
                end
            end
            K_SENT: begin
                idx = lookup(s);
                if (idx >= 0) begin
                    sh_sent[idx] = 1'b1;
                    sh_stamp[idx] = now;
                end
                b = {b, t_beat'{32'd0, idx >= 0, 1'b1, 32'd0}};
            end
            K_TICK: begin
                rto = clamped_timeout();
                for (int i = 0; i < DEPTH; i++) begin
                    if (sh_valid[i] && sh_sent[i] && now >= sh_stamp[i]
                        && now - sh_stamp[i] >= rto) begin
                        sh_stamp[i] = now;
                        b = {b, t_beat'{sh_seq[i], 1'b1, 1'b0, 32'd0}};
                    end
                end
                if (b.size() == 0) b = {b, t_beat'{32'd0, 1'b0, 1'b1, 32'd0}};
                else b[b.size()-1].last = 1'b1;
            end
            default: begin
                idx = lookup(s);
                if (idx >= 0) begin
                    if (sh_sent[idx] && now >= sh_stamp[idx]) fold_sample(now - sh_stamp[idx]);
                    for (int i = idx; i + 1 < DEPTH; i++) begin
                        sh_valid[i] = sh_valid[i+1];
                        sh_seq[i] = sh_seq[i+1];
                        sh_sent[i] = sh_sent[i+1];
                        sh_stamp[i] = sh_stamp[i+1];
                    end
                    sh_valid[DEPTH-1] = 1'b0;
                end
                b = {b, t_beat'{32'd0, idx >= 0, 1'b1, 32'd0}};
            end
        endcase
        rto = clamped_timeout();
        foreach (b[i]) begin
            b[i].rto = rto;
            pending_beats = {pending_beats, b[i]};
        end
    endfunction

    // Result checker and stall watchdog
    always @(posedge i_clk) begin
        t_beat e;
        if ((i_start && !o_busy) || o_result_valid) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && o_result_valid) begin
            if (pending_beats.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result beat seq=%h", o_sequence_out);
            end else begin
                e = pending_beats.pop_front();
                if (o_sequence_out !== e.seq || o_ok !== e.ok || o_last !== e.last
                    || o_retry_timeout_ms !== e.rto) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("beat mismatch: exp seq=%h ok=%b last=%b rto=%h got %h %b %b %h",
                                 e.seq, e.ok, e.last, e.rto, o_sequence_out, o_ok, o_last,
                                 o_retry_timeout_ms);
                end
            end
        end
    end

    // Drive one command and wait for the block to take it
    task automatic send_cmd(input t_kind k, input logic [31:0] s, input logic [31:0] now);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_kind <= k;
        i_sequence_req <= s;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_busy);
        predict_beats(k, s, now);
    endtask

    // Drain, let the block settle, then write all three registers
    task automatic write_regs(input logic [31:0] init_v, input logic [31:0] min_v,
                              input logic [31:0] max_v);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_INITIAL_RTT;
        i_cfg_data <= init_v;
        @(posedge i_clk);
        sh_init = init_v;
        reload_rtt();
        i_cfg_index <= CFG_MIN_TIMEOUT;
        i_cfg_data <= min_v;
        @(posedge i_clk);
        sh_min = min_v;
        i_cfg_index <= CFG_MAX_TIMEOUT;
        i_cfg_data <= max_v;
        @(posedge i_clk);
        sh_max = max_v;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(9))
            0:       return $urandom;
            1, 2:    return wall_ms + 32'($urandom_range(0, 50));
            3, 4, 5: return wall_ms + clamped_timeout() + 32'($urandom_range(0, 20)) - 32'd5;
            default: return wall_ms + 32'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [31:0] pick_pending();
        int cnt;
        cnt = 0;
        while (cnt < DEPTH && sh_valid[cnt]) cnt++;
        if (cnt == 0 || $urandom_range(9) == 0) return $urandom;
        return sh_seq[$urandom_range(0, cnt - 1)];
    endfunction

    initial begin
        t_row        rows[$];
        t_kind       k;
        logic [31:0] cfg_sets[5][3];
        t_beat       got;

        cfg_sets = '{'{32'd0, 32'd0, 32'hFFFF_FFFF},
                     '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                     '{32'd50, 32'd3000, 32'd1000},
                     '{32'd30, 32'd100, 32'd400},
                     '{32'd1000, 32'd0, 32'd0}};

        // Directed rows: unknown sequences, empty tick, RTT sample, time backwards, full table
        rows = '{'{K_ACK, 32'd5, 32'd0, 1, 32'd0, 1'b0},
                 '{K_SENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 1'b0},
                 '{K_TICK, 32'd0, 32'hFFFF_FFFF, 1, 32'd0, 1'b0},
                 '{K_REGISTER, 32'hFFFF_FFFF, 32'd0, 1, 32'd1, 1'b1},
                 '{K_REGISTER, 32'd0, 32'd0, 1, 32'd2, 1'b1},
                 '{K_ACK, 32'd2, 32'd0, 1, 32'd0, 1'b1},
                 '{K_REGISTER, 32'd0, 32'd0, 1, 32'd3, 1'b1},
                 '{K_SENT, 32'd1, 32'd0, 1, 32'd0, 1'b1},
                 '{K_SENT, 32'd3, 32'd100, 0, 32'd0, 1'b0},
                 '{K_TICK, 32'd0, 32'd500, 0, 32'd0, 1'b0},
                 '{K_TICK, 32'd0, 32'd700, 0, 32'd0, 1'b0},
                 '{K_ACK, 32'd1, 32'd900, 0, 32'd0, 1'b0},
                 '{K_ACK, 32'd3, 32'd50, 0, 32'd0, 1'b0}};
        for (int i = 0; i < DEPTH; i++)
            rows = {rows, t_row'{K_REGISTER, 32'd0, 32'd0, 0, 32'd0, 1'b0}};
        rows = {rows, t_row'{K_REGISTER, 32'd0, 32'd0, 1, 32'd0, 1'b0}};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Typed rows cause a single beat, the newest one predicted
        foreach (rows[i]) begin
            send_cmd(rows[i].kind, rows[i].seq, rows[i].now);
            got = pending_beats[pending_beats.size() - 1];
            if (rows[i].typed && (got.seq !== rows[i].exp_seq || got.ok !== rows[i].exp_ok)) begin
                errors++;
                if (mismatches++ < 10)
                    $display("directed row %0d: exp seq=%h ok=%b predicted seq=%h ok=%b",
                             i, rows[i].exp_seq, rows[i].exp_ok, got.seq, got.ok);
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < 5; p++) begin
            write_regs(cfg_sets[p][0], cfg_sets[p][1], cfg_sets[p][2]);
            no_idle = (p == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5: k = K_REGISTER;
                    6, 7, 8, 9, 10:   k = K_SENT;
                    11, 12, 13, 14:   k = K_TICK;
                    default:          k = K_ACK;
                endcase
                wall_ms = pick_time();
                send_cmd(k, pick_pending(), wall_ms);
            end
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0 || o_busy) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (errors == 0 && pending_beats.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
